// ----- design/mme_pkg.sv -----
`timescale 1ns / 1ps
// Package for the matrix multiply engine: sizes, opcodes, register indexes,
// pipeline tag type and dimension helper. No dependencies.
package mme_pkg;

   localparam int MAX_DIM         = 8;
   localparam int ELEM_WIDTH      = 16;
   localparam int DEPTH           = MAX_DIM * MAX_DIM;
   localparam int ADDR_WIDTH      = $clog2(DEPTH);
   localparam int CNT_WIDTH       = $clog2(MAX_DIM);
   localparam int IDX_WIDTH       = 3;
   localparam int CSR_WIDTH       = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int PROD_WIDTH      = 2 * ELEM_WIDTH;
   localparam int SUM_WIDTH       = 35;
   localparam logic [CSR_WIDTH-1:0] DIM_RESET = CSR_WIDTH'(8);

   typedef enum logic [1:0] {
      OP_WRITE_A  = 2'd0,
      OP_WRITE_B  = 2'd1,
      OP_COMPUTE  = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROWS_A     = 2'd0,
      CSR_INNER_SIZE = 2'd1,
      CSR_COLS_B     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 first;
      logic                 last;
      logic                 final_elem;
      logic [CNT_WIDTH-1:0] row;
      logic [CNT_WIDTH-1:0] col;
   } tag_type;

   // Effective dimension minus one: zero counts as one, clamp to MAX_DIM.
   function automatic logic [CNT_WIDTH-1:0] dim_last(input logic [CSR_WIDTH-1:0] v);
      int d;
      d = int'(v);
      if (d == 0) d = 1;
      if (d > MAX_DIM) d = MAX_DIM;
      return CNT_WIDTH'(d - 1);
   endfunction

endpackage

// ----- design/mme_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the matrix multiply engine.
// Depends on mme_pkg.
interface mme_req_if;
   import mme_pkg::*;
   logic                          valid;
   logic                          ready;
   opcode_type                    opcode;
   logic [IDX_WIDTH-1:0]          row_index;
   logic [IDX_WIDTH-1:0]          col_index;
   logic signed [ELEM_WIDTH-1:0]  element_value;

   modport source (output valid, opcode, row_index, col_index, element_value, input ready);
   modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mme_rsp_if;
   import mme_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [IDX_WIDTH-1:0]         out_row;
   logic [IDX_WIDTH-1:0]         out_col;
   logic signed [SUM_WIDTH-1:0]  product_value;
   logic                         last_element;

   modport source (output valid, out_row, out_col, product_value, last_element, input ready);
   modport sink   (input valid, out_row, out_col, product_value, last_element, output ready);
endinterface

// ----- design/mme_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- design/matrix_multiply_engine.sv -----
`timescale 1ns / 1ps
// Matrix multiply engine top level: two element stores, read-multiply-
// accumulate pipeline, sequencer and output register. Depends on mme_pkg,
// mme_if and mme_ram.

// Element writes (opcodes 0 and 1) are taken one per cycle while the engine
// is idle. A compute command emits rows_a x cols_b results in row-major
// order; each result reads one element per cycle from each store through a
// read / multiply / accumulate pipeline and does not start while the previous
// result still waits in the output register. No new command is taken until
// the last result has been loaded into the output register. Stores are not
// cleared at reset; only entries written before a compute are meaningful.
module matrix_multiply_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   mme_req_if.sink                              req_if,
   mme_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [mme_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mme_pkg::CSR_WIDTH-1:0]        csr_wdata
);
   import mme_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_type;

   state_type                    state_ff, state_in;
   logic [CSR_WIDTH-1:0]         rows_a_ff, inner_size_ff, cols_b_ff;
   logic [CNT_WIDTH-1:0]         m_last_ff, k_last_ff, n_last_ff;
   logic [CNT_WIDTH-1:0]         m_last_in, k_last_in, n_last_in;
   logic [CNT_WIDTH-1:0]         i_ff, j_ff, t_ff, i_in, j_in, t_in;
   logic                         p1_valid_ff, p2_valid_ff;
   tag_type                      p1_tag_ff, p2_tag_ff, issue_tag;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic signed [SUM_WIDTH-1:0]  acc_ff, acc_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [IDX_WIDTH-1:0]         out_row_ff, out_col_ff;
   logic signed [SUM_WIDTH-1:0]  product_ff;
   logic                         last_ff;

   logic                  req_xfer, rsp_xfer, issue, load, wr_ok;
   logic                  wr_a_en, wr_b_en;
   logic [ADDR_WIDTH-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [ELEM_WIDTH-1:0] a_rd, b_rd;

   assign req_if.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign rsp_xfer     = rsp_valid_ff && rsp_if.ready;

   assign wr_ok   = (int'(req_if.row_index) < MAX_DIM) && (int'(req_if.col_index) < MAX_DIM);
   assign wr_a_en = req_xfer && wr_ok && (req_if.opcode == OP_WRITE_A);
   assign wr_b_en = req_xfer && wr_ok && (req_if.opcode == OP_WRITE_B);
   assign wr_addr = ADDR_WIDTH'(int'(req_if.row_index) * MAX_DIM + int'(req_if.col_index));

   assign rd_a_addr = ADDR_WIDTH'(int'(i_ff) * MAX_DIM + int'(t_ff));
   assign rd_b_addr = ADDR_WIDTH'(int'(t_ff) * MAX_DIM + int'(j_ff));

   mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (wr_a_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.element_value),
      .rd_addr (rd_a_addr),
      .rd_data (a_rd)
   );

   mme_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (wr_b_en),
      .wr_addr (wr_addr),
      .wr_data (req_if.element_value),
      .rd_addr (rd_b_addr),
      .rd_data (b_rd)
   );

   // A new dot product starts only with the output register empty, so the
   // load at its end never collides with a waiting result.
   assign issue = (state_ff == S_RUN) && !((t_ff == '0) && rsp_valid_ff);

   always_comb begin
      issue_tag.first      = (t_ff == '0);
      issue_tag.last       = (t_ff == k_last_ff);
      issue_tag.final_elem = (i_ff == m_last_ff) && (j_ff == n_last_ff);
      issue_tag.row        = i_ff;
      issue_tag.col        = j_ff;
   end

   assign load   = p2_valid_ff && p2_tag_ff.last;
   assign acc_in = (p2_tag_ff.first ? '0 : acc_ff) + SUM_WIDTH'(prod_ff);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      t_in      = t_ff;
      m_last_in = m_last_ff;
      k_last_in = k_last_ff;
      n_last_in = n_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_if.opcode == OP_COMPUTE)) begin
               m_last_in = dim_last(rows_a_ff);
               k_last_in = dim_last(inner_size_ff);
               n_last_in = dim_last(cols_b_ff);
               i_in      = '0;
               j_in      = '0;
               t_in      = '0;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            if (issue) begin
               if (t_ff == k_last_ff) begin
                  t_in     = '0;
                  state_in = S_DRAIN;
               end else begin
                  t_in = t_ff + CNT_WIDTH'(1);
               end
            end
         end
         S_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               if (issue_tag.final_elem) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_RUN;
                  if (j_ff == n_last_ff) begin
                     j_in = '0;
                     i_in = i_ff + CNT_WIDTH'(1);
                  end else begin
                     j_in = j_ff + CNT_WIDTH'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         rows_a_ff     <= DIM_RESET;
         inner_size_ff <= DIM_RESET;
         cols_b_ff     <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= issue;
         p2_valid_ff  <= p1_valid_ff;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ROWS_A:     rows_a_ff     <= csr_wdata;
               CSR_INNER_SIZE: inner_size_ff <= csr_wdata;
               CSR_COLS_B:     cols_b_ff     <= csr_wdata;
               default:        ;
            endcase
         end
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      t_ff      <= t_in;
      m_last_ff <= m_last_in;
      k_last_ff <= k_last_in;
      n_last_ff <= n_last_in;
      p1_tag_ff <= issue_tag;
      p2_tag_ff <= p1_tag_ff;
      prod_ff   <= $signed(a_rd) * $signed(b_rd);
      if (p2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (load) begin
         out_row_ff <= IDX_WIDTH'(p2_tag_ff.row);
         out_col_ff <= IDX_WIDTH'(p2_tag_ff.col);
         product_ff <= acc_in;
         last_ff    <= p2_tag_ff.final_elem;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.out_row       = out_row_ff;
   assign rsp_if.out_col       = out_col_ff;
   assign rsp_if.product_value = product_ff;
   assign rsp_if.last_element  = last_ff;

`ifndef NO_ASSERTIONS
   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> !rsp_valid_ff)
      else $error("result loaded over a waiting result");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!p1_valid_ff && !p2_valid_ff))
      else $error("pipeline busy while idle");

   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (load && p2_tag_ff.final_elem) |-> (p2_tag_ff.row == m_last_ff &&
                                          p2_tag_ff.col == n_last_ff))
      else $error("last element flagged at wrong position");
`endif

endmodule
